FILE: design/els_pkg.sv
package els_pkg;

  // Value format
  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Divide / square root unit
  localparam int DS_NUM_W = 50;
  localparam int DS_DEN_W = 25;
  localparam int DS_REM_W = 28;
  localparam int DS_STEPS = DS_NUM_W / 2;
  localparam int DS_CNT_W = $clog2(DS_STEPS);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 31;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BOOST   = 3'd0,
    REG_DT      = 3'd1,
    REG_SPACING = 3'd2,
    REG_RADIUS  = 3'd3,
    REG_ROWS    = 3'd4,
    REG_COLS    = 3'd5,
    REG_TOP     = 3'd6,
    REG_END     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_vx;
    logic signed [31:0] load_vy;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic              hit_atom;
    logic              hit_wall;
    logic              reached_end;
  } result_t;

  // Control into the divide / square root unit
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } ds_ctrl_t;

  // p / 2^FRAC_BITS, round to nearest, ties away from zero
  function automatic logic signed [63:0] rescale(input logic signed [63:0] p);
    logic [63:0] m;
    m = p[63] ? (~p + 64'd1) : p;
    m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    rescale = p[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    logic signed [63:0] c;
    if (v > VMAX) c = VMAX;
    else if (v < VMIN) c = VMIN;
    else c = v;
    sat = c[31:0];
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    neg_sat = sat(-w);
  endfunction

endpackage

FILE: design/electron_lattice_step.sv
// Channel  | Direction | Handshake                  | Payload
// item     | in        | item_valid / item_ready    | item_t (operation, load fields)
// result   | out       | result_valid / result_ready| result_t (state and flags)
// cfg      | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A load request goes from idle straight to the done step, which fills the result
// register. A tick without an atom test (empty lattice) skips the divide/square root
// unit; a full hit uses it for two index divides, one root and four divides, and
// uses the shared multiplier for each product.
// Reset is synchronous: it clears control and particle state and sets the config
// defaults. A new request is taken while a finished result waits; the next result
// holds in the last step until the result register is free. cfg is always ready.
module electron_lattice_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  els_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output els_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [els_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [els_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import els_pkg::*;

  typedef enum logic [37:0] {
    ST_IDLE   = 38'd1 << 0,
    ST_MBOOST = 38'd1 << 1,
    ST_VX     = 38'd1 << 2,
    ST_MVX    = 38'd1 << 3,
    ST_X      = 38'd1 << 4,
    ST_Y      = 38'd1 << 5,
    ST_WTOP   = 38'd1 << 6,
    ST_WBOT   = 38'd1 << 7,
    ST_COL    = 38'd1 << 8,
    ST_COLW   = 38'd1 << 9,
    ST_ROW    = 38'd1 << 10,
    ST_ROWW   = 38'd1 << 11,
    ST_MAX    = 38'd1 << 12,
    ST_MAY    = 38'd1 << 13,
    ST_AY     = 38'd1 << 14,
    ST_DIFF   = 38'd1 << 15,
    ST_CHK    = 38'd1 << 16,
    ST_DX2    = 38'd1 << 17,
    ST_DY2    = 38'd1 << 18,
    ST_R2     = 38'd1 << 19,
    ST_SQW    = 38'd1 << 20,
    ST_MDXR   = 38'd1 << 21,
    ST_VDXR   = 38'd1 << 22,
    ST_WDXR   = 38'd1 << 23,
    ST_MDYR   = 38'd1 << 24,
    ST_VDYR   = 38'd1 << 25,
    ST_WDYR   = 38'd1 << 26,
    ST_VUX    = 38'd1 << 27,
    ST_WUX    = 38'd1 << 28,
    ST_VUY    = 38'd1 << 29,
    ST_WUY    = 38'd1 << 30,
    ST_MVUX   = 38'd1 << 31,
    ST_MVUY   = 38'd1 << 32,
    ST_DOT    = 38'd1 << 33,
    ST_MDUX   = 38'd1 << 34,
    ST_MDUY   = 38'd1 << 35,
    ST_VYF    = 38'd1 << 36,
    ST_DONE   = 38'd1 << 37
  } state_t;

  state_t state;

  // configuration
  logic [23:0] boost, atom_spacing, atom_radius;
  logic [16:0] time_step;
  logic [10:0] atom_rows, atom_cols;
  logic [30:0] wall_top, end_x;

  // particle state and work registers
  logic signed [31:0] px, py, pvx, pvy;
  logic               hit_atom, hit_wall;
  logic [10:0]        col, row;
  logic [34:0]        ax, ay;
  logic signed [35:0] dx, dy;
  logic [49:0]        d2;
  logic [24:0]        droot;
  logic signed [17:0] ux, uy;
  logic signed [61:0] acc;
  logic signed [33:0] dot;
  logic               neg_r;
  result_t            res_q;
  logic               publish;

  // shared units
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  ds_ctrl_t                  ds_ctrl;
  logic [DS_NUM_W-1:0]       ds_num, ds_q;
  logic [DS_DEN_W-1:0]       ds_den;
  logic                      ds_busy, ds_done;

  els_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  els_divsqrt u_ds (
    .clk(clk), .rst(rst), .ctrl(ds_ctrl), .num(ds_num), .den(ds_den),
    .busy(ds_busy), .done(ds_done), .q(ds_q)
  );

  // widened views
  logic signed [63:0] px64, py64, pvx64, pvy64, prod64, wt64, ex64, ax64, ay64, qs64;
  logic [35:0]        dx_mag, dy_mag;
  logic [61:0]        prod_mag;
  logic               lattice_ok;

  assign px64   = 64'(px);
  assign py64   = 64'(py);
  assign pvx64  = 64'(pvx);
  assign pvy64  = 64'(pvy);
  assign prod64 = 64'(prod);
  assign wt64   = 64'(wall_top);
  assign ex64   = 64'(end_x);
  assign ax64   = 64'(ax);
  assign ay64   = 64'(ay);
  assign qs64   = neg_r ? -$signed(64'(ds_q[25:0])) : $signed(64'(ds_q[25:0]));
  assign dx_mag   = dx[35] ? 36'(-dx) : 36'(dx);
  assign dy_mag   = dy[35] ? 36'(-dy) : 36'(dy);
  assign prod_mag = prod[61] ? 62'(-prod) : 62'(prod);
  assign lattice_ok = (atom_rows != '0) && (atom_cols != '0);

  assign item_ready   = (state == ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign result       = res_q;
  assign publish      = (state == ST_DONE) && (!result_valid || result_ready);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MBOOST: begin mul_a = MUL_A_W'(boost);        mul_b = MUL_B_W'(time_step); end
      ST_MVX:    begin mul_a = MUL_A_W'(pvx);          mul_b = MUL_B_W'(time_step); end
      ST_X:      begin mul_a = MUL_A_W'(pvy);          mul_b = MUL_B_W'(time_step); end
      ST_MAX:    begin mul_a = MUL_A_W'(atom_spacing); mul_b = MUL_B_W'(col); end
      ST_MAY:    begin mul_a = MUL_A_W'(atom_spacing); mul_b = MUL_B_W'(row); end
      ST_CHK:    begin mul_a = dx;                     mul_b = dx[MUL_B_W-1:0]; end
      ST_DX2:    begin mul_a = dy;                     mul_b = dy[MUL_B_W-1:0]; end
      ST_DY2:    begin mul_a = MUL_A_W'(atom_radius);  mul_b = MUL_B_W'(atom_radius); end
      ST_MDXR:   begin mul_a = dx;                     mul_b = MUL_B_W'(atom_radius); end
      ST_MDYR:   begin mul_a = dy;                     mul_b = MUL_B_W'(atom_radius); end
      ST_MVUX:   begin mul_a = MUL_A_W'(pvx);          mul_b = MUL_B_W'(ux); end
      ST_MVUY:   begin mul_a = MUL_A_W'(pvy);          mul_b = MUL_B_W'(uy); end
      ST_MDUX:   begin mul_a = MUL_A_W'(dot);          mul_b = MUL_B_W'(ux); end
      ST_MDUY:   begin mul_a = MUL_A_W'(dot);          mul_b = MUL_B_W'(uy); end
      default:   begin mul_a = '0;                     mul_b = '0; end
    endcase
  end

  // divide / root launch
  always_comb begin
    ds_ctrl = '0;
    ds_num  = '0;
    ds_den  = '0;
    unique case (state)
      ST_COL: begin
        ds_ctrl.start = lattice_ok && (atom_spacing != '0) && !px[31] && (px != '0);
        ds_num = DS_NUM_W'(px[30:0]) + DS_NUM_W'(atom_spacing >> 1);
        ds_den = DS_DEN_W'(atom_spacing);
      end
      ST_ROW: begin
        ds_ctrl.start = (atom_spacing != '0) && !py[31] && (py != '0);
        ds_num = DS_NUM_W'(py[30:0]) + DS_NUM_W'(atom_spacing >> 1);
        ds_den = DS_DEN_W'(atom_spacing);
      end
      ST_R2: begin
        ds_ctrl.start     = (d2 != '0) && (d2 <= prod[49:0]);
        ds_ctrl.sqrt_mode = 1'b1;
        ds_num = d2;
      end
      ST_VDXR, ST_VDYR: begin
        ds_ctrl.start = 1'b1;
        ds_num = prod_mag[DS_NUM_W-1:0] + DS_NUM_W'(droot >> 1);
        ds_den = droot;
      end
      ST_VUX: begin
        ds_ctrl.start = 1'b1;
        ds_num = DS_NUM_W'({dx_mag[24:0], 16'b0}) + DS_NUM_W'(droot >> 1);
        ds_den = droot;
      end
      ST_VUY: begin
        ds_ctrl.start = 1'b1;
        ds_num = DS_NUM_W'({dy_mag[24:0], 16'b0}) + DS_NUM_W'(droot >> 1);
        ds_den = droot;
      end
      default: ds_ctrl = '0;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      boost        <= 24'd6553600;
      time_step    <= 17'd655;
      atom_spacing <= 24'd655360;
      atom_radius  <= 24'd65536;
      atom_rows    <= 11'd11;
      atom_cols    <= 11'd101;
      wall_top     <= 31'd6553600;
      end_x        <= 31'd65536000;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOOST:   boost        <= cfg_data[23:0];
        REG_DT:      time_step    <= cfg_data[16:0];
        REG_SPACING: atom_spacing <= cfg_data[23:0];
        REG_RADIUS:  atom_radius  <= cfg_data[23:0];
        REG_ROWS:    atom_rows    <= cfg_data[10:0];
        REG_COLS:    atom_cols    <= cfg_data[10:0];
        REG_TOP:     wall_top     <= cfg_data;
        REG_END:     end_x        <= cfg_data;
        default:     boost        <= boost;
      endcase
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (publish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // sequencer and particle state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      px           <= '0;
      py           <= '0;
      pvx          <= '0;
      pvy          <= '0;
      hit_atom     <= 1'b0;
      hit_wall     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (item_valid) begin
          hit_atom <= 1'b0;
          hit_wall <= 1'b0;
          if (item.operation) begin
            px    <= item.load_x;
            py    <= item.load_y;
            pvx   <= item.load_vx;
            pvy   <= item.load_vy;
            state <= ST_DONE;
          end else begin
            state <= ST_MBOOST;
          end
        end
        ST_MBOOST: state <= ST_VX;
        ST_VX: begin
          pvx   <= sat(pvx64 + rescale(prod64));
          state <= ST_MVX;
        end
        ST_MVX: state <= ST_X;
        ST_X: begin
          px    <= sat(px64 + rescale(prod64));
          state <= ST_Y;
        end
        ST_Y: begin
          py    <= sat(py64 + rescale(prod64));
          state <= ST_WTOP;
        end
        ST_WTOP: begin
          if (py64 >= wt64) begin
            py       <= sat(wt64 - ONE_Q);
            pvy      <= neg_sat(pvy);
            hit_wall <= 1'b1;
          end
          state <= ST_WBOT;
        end
        ST_WBOT: begin
          if (py <= 32'sd0) begin
            py       <= sat(ONE_Q);
            pvy      <= neg_sat(pvy);
            hit_wall <= 1'b1;
          end
          state <= ST_COL;
        end
        // nearest column, then row
        ST_COL: begin
          if (!lattice_ok) begin
            state <= ST_DONE;
          end else if (ds_ctrl.start) begin
            state <= ST_COLW;
          end else begin
            col   <= '0;
            state <= ST_ROW;
          end
        end
        ST_COLW: if (ds_done) begin
          if (ds_q > DS_NUM_W'(atom_cols - 11'd1)) col <= atom_cols - 11'd1;
          else col <= ds_q[10:0];
          state <= ST_ROW;
        end
        ST_ROW: begin
          if (ds_ctrl.start) begin
            state <= ST_ROWW;
          end else begin
            row   <= '0;
            state <= ST_MAX;
          end
        end
        ST_ROWW: if (ds_done) begin
          if (ds_q > DS_NUM_W'(atom_rows - 11'd1)) row <= atom_rows - 11'd1;
          else row <= ds_q[10:0];
          state <= ST_MAX;
        end
        ST_MAX: state <= ST_MAY;
        ST_MAY: begin
          ax    <= prod[34:0];
          state <= ST_AY;
        end
        ST_AY: begin
          ay    <= prod[34:0];
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          dx    <= 36'(px64 - ax64);
          dy    <= 36'(py64 - ay64);
          state <= ST_CHK;
        end
        // box test, then squared distance against radius squared
        ST_CHK: begin
          if ((dx_mag > 36'(atom_radius)) || (dy_mag > 36'(atom_radius))) state <= ST_DONE;
          else state <= ST_DX2;
        end
        ST_DX2: begin
          d2    <= prod[49:0];
          state <= ST_DY2;
        end
        ST_DY2: begin
          d2    <= d2 + prod[49:0];
          state <= ST_R2;
        end
        ST_R2: begin
          if (d2 > prod[49:0]) begin
            state <= ST_DONE;
          end else if (d2 == '0) begin
            pvx      <= neg_sat(pvx);
            pvy      <= neg_sat(pvy);
            hit_atom <= 1'b1;
            state    <= ST_DONE;
          end else begin
            state <= ST_SQW;
          end
        end
        ST_SQW: if (ds_done) begin
          droot <= ds_q[24:0];
          state <= ST_MDXR;
        end
        // push out to the radius
        ST_MDXR: state <= ST_VDXR;
        ST_VDXR: begin
          neg_r <= prod[61];
          state <= ST_WDXR;
        end
        ST_WDXR: if (ds_done) begin
          px    <= sat(ax64 + qs64);
          state <= ST_MDYR;
        end
        ST_MDYR: state <= ST_VDYR;
        ST_VDYR: begin
          neg_r <= prod[61];
          state <= ST_WDYR;
        end
        ST_WDYR: if (ds_done) begin
          py    <= sat(ay64 + qs64);
          state <= ST_VUX;
        end
        // unit normal
        ST_VUX: begin
          neg_r <= dx[35];
          state <= ST_WUX;
        end
        ST_WUX: if (ds_done) begin
          ux    <= 18'(qs64);
          state <= ST_VUY;
        end
        ST_VUY: begin
          neg_r <= dy[35];
          state <= ST_WUY;
        end
        ST_WUY: if (ds_done) begin
          uy    <= 18'(qs64);
          state <= ST_MVUX;
        end
        // reflect the normal component
        ST_MVUX: state <= ST_MVUY;
        ST_MVUY: begin
          acc   <= prod;
          state <= ST_DOT;
        end
        ST_DOT: begin
          dot   <= 34'(rescale(64'(acc) + prod64));
          state <= ST_MDUX;
        end
        ST_MDUX: state <= ST_MDUY;
        ST_MDUY: begin
          pvx   <= sat(pvx64 - (rescale(prod64) <<< 1));
          state <= ST_VYF;
        end
        ST_VYF: begin
          pvy      <= sat(pvy64 - (rescale(prod64) <<< 1));
          hit_atom <= 1'b1;
          state    <= ST_DONE;
        end
        ST_DONE: if (publish) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (publish) begin
      res_q.pos_x       <= px;
      res_q.pos_y       <= py;
      res_q.vel_x       <= pvx;
      res_q.vel_y       <= pvy;
      res_q.hit_atom    <= hit_atom;
      res_q.hit_wall    <= hit_wall;
      res_q.reached_end <= (px64 >= ex64);
    end
  end

  // checks
  a_ds_idle_start: assert property (@(posedge clk) disable iff (rst)
    ds_ctrl.start |-> !ds_busy)
    else $error("divide unit started while busy");

  a_done_publish: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && (!result_valid || result_ready)) |=>
      (result_valid && (state == ST_IDLE)))
    else $error("finished item not published");

  a_ds_done_wait: assert property (@(posedge clk) disable iff (rst)
    ds_done |-> ((state == ST_COLW) || (state == ST_ROWW) || (state == ST_SQW) ||
                 (state == ST_WDXR) || (state == ST_WDYR) || (state == ST_WUX) ||
                 (state == ST_WUY)))
    else $error("divide result arrived outside a wait step");

  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.operation) |=> (state == ST_DONE))
    else $error("load request did not finish at once");

endmodule

FILE: design/els_mul.sv
module els_mul (
  input  logic                                clk,
  input  logic signed [els_pkg::MUL_A_W-1:0]  a,
  input  logic signed [els_pkg::MUL_B_W-1:0]  b,
  output logic signed [els_pkg::MUL_P_W-1:0]  prod
);
  import els_pkg::*;

  // registered product
  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

FILE: design/els_divsqrt.sv
module els_divsqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  els_pkg::ds_ctrl_t             ctrl,
  input  logic [els_pkg::DS_NUM_W-1:0]  num,
  input  logic [els_pkg::DS_DEN_W-1:0]  den,
  output logic                          busy,
  output logic                          done,
  output logic [els_pkg::DS_NUM_W-1:0]  q
);
  import els_pkg::*;

  logic [DS_CNT_W-1:0] cnt;
  logic                mode;
  logic [DS_NUM_W-1:0] sh, sh_next;
  logic [DS_REM_W-1:0] rem, rem_next;
  logic [DS_NUM_W-1:0] quo, quo_next;
  logic [DS_DEN_W-1:0] den_r;

  // one step: two divide bits or one root bit
  always_comb begin
    logic [DS_DEN_W:0]   r;
    logic [DS_REM_W-1:0] rs;
    logic [DS_REM_W-1:0] trial;
    sh_next  = sh;
    rem_next = rem;
    quo_next = quo;
    r        = '0;
    rs       = '0;
    trial    = '0;
    if (mode) begin
      rs    = {rem[DS_REM_W-3:0], sh[DS_NUM_W-1 -: 2]};
      trial = DS_REM_W'({quo[DS_DEN_W-1:0], 2'b01});
      sh_next = sh << 2;
      if (rs >= trial) begin
        rem_next = rs - trial;
        quo_next = {quo[DS_NUM_W-2:0], 1'b1};
      end else begin
        rem_next = rs;
        quo_next = {quo[DS_NUM_W-2:0], 1'b0};
      end
    end else begin
      for (int j = 0; j < 2; j++) begin
        r = {rem_next[DS_DEN_W-1:0], sh_next[DS_NUM_W-1]};
        sh_next = sh_next << 1;
        if (r >= {1'b0, den_r}) begin
          r = r - {1'b0, den_r};
          quo_next = {quo_next[DS_NUM_W-2:0], 1'b1};
        end else begin
          quo_next = {quo_next[DS_NUM_W-2:0], 1'b0};
        end
        rem_next = DS_REM_W'(r);
      end
    end
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DS_CNT_W'(DS_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mode  <= ctrl.sqrt_mode;
      sh    <= num;
      rem   <= '0;
      quo   <= '0;
      den_r <= den;
    end else if (busy) begin
      sh  <= sh_next;
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign q = quo;

endmodule

FILE: tb/lattice_checker.sv
`timescale 1ns / 1ps

// Watches the three channels, keeps its own particle model and compares every result.
module lattice_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_ready,
  input  els_pkg::item_t                  item,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  els_pkg::result_t                result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [els_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [els_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              errors,
  output int                              pending
);
  import els_pkg::*;

  localparam longint ONE = 64'sd65536;

  // register copies and particle state
  longint boost_r, dt_r, spacing_r, radius_r, rows_r, cols_r, top_r, end_r;
  longint px, py, vx, vy;
  result_t expected_q[$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint round_q16(longint p);
    longint m;
    m = (magn(p) + 64'sd32768) >> 16;
    return p < 0 ? -m : m;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint m;
    m = (magn(num) + den / 2) / den;
    return num < 0 ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint lattice_index(longint p, longint sp, longint n);
    longint k;
    if (sp == 0 || p <= 0) return 0;
    k = (p + sp / 2) / sp;
    return k > n - 1 ? n - 1 : k;
  endfunction

  // nearest atom test and bounce; updates particle state
  function automatic bit atom_bounce();
    longint c, r, ax, ay, dx, dy, d2, d, ux, uy, dot;
    if (rows_r == 0 || cols_r == 0) return 1'b0;
    c = lattice_index(px, spacing_r, cols_r);
    r = lattice_index(py, spacing_r, rows_r);
    ax = c * spacing_r;
    ay = r * spacing_r;
    dx = px - ax;
    dy = py - ay;
    if (magn(dx) > radius_r || magn(dy) > radius_r) return 1'b0;
    d2 = dx * dx + dy * dy;
    if (d2 > radius_r * radius_r) return 1'b0;
    // particle exactly on the center: plain reversal
    if (d2 == 0) begin
      vx = clip32(-vx);
      vy = clip32(-vy);
      return 1'b1;
    end
    d = int_sqrt(d2);
    px = clip32(ax + round_div(dx * radius_r, d));
    py = clip32(ay + round_div(dy * radius_r, d));
    ux = round_div(dx * ONE, d);
    uy = round_div(dy * ONE, d);
    dot = round_q16(vx * ux + vy * uy);
    vx = clip32(vx - 2 * round_q16(dot * ux));
    vy = clip32(vy - 2 * round_q16(dot * uy));
    return 1'b1;
  endfunction

  function automatic result_t particle_step(item_t it);
    result_t r;
    bit wall, atom;
    wall = 1'b0;
    atom = 1'b0;
    if (it.operation) begin
      px = longint'($signed(it.load_x));
      py = longint'($signed(it.load_y));
      vx = longint'($signed(it.load_vx));
      vy = longint'($signed(it.load_vy));
    end else begin
      vx = clip32(vx + round_q16(boost_r * dt_r));
      px = clip32(px + round_q16(vx * dt_r));
      py = clip32(py + round_q16(vy * dt_r));
      // top wall first, then bottom
      if (py >= top_r) begin
        py = clip32(top_r - ONE);
        vy = clip32(-vy);
        wall = 1'b1;
      end
      if (py <= 0) begin
        py = ONE;
        vy = clip32(-vy);
        wall = 1'b1;
      end
      atom = atom_bounce();
    end
    r.pos_x = px[31:0];
    r.pos_y = py[31:0];
    r.vel_x = vx[31:0];
    r.vel_y = vy[31:0];
    r.hit_atom = atom;
    r.hit_wall = wall;
    r.reached_end = px >= end_r;
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  assign pending = expected_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      boost_r = 6553600; dt_r = 655; spacing_r = 655360; radius_r = 65536;
      rows_r = 11; cols_r = 101; top_r = 6553600; end_r = 65536000;
      px = 0; py = 0; vx = 0; vy = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOOST:   boost_r = cfg_data & 31'hFFFFFF;
          REG_DT:      dt_r = cfg_data & 31'h1FFFF;
          REG_SPACING: spacing_r = cfg_data & 31'hFFFFFF;
          REG_RADIUS:  radius_r = cfg_data & 31'hFFFFFF;
          REG_ROWS:    rows_r = cfg_data & 31'h7FF;
          REG_COLS:    cols_r = cfg_data & 31'h7FF;
          REG_TOP:     top_r = cfg_data;
          REG_END:     end_r = cfg_data;
          default: ;
        endcase
      end
      // result first: it belongs to an older request
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("pos_x", $signed(e.pos_x), $signed(result.pos_x));
          check_field("pos_y", $signed(e.pos_y), $signed(result.pos_y));
          check_field("vel_x", $signed(e.vel_x), $signed(result.vel_x));
          check_field("vel_y", $signed(e.vel_y), $signed(result.vel_y));
          check_field("hit_atom", e.hit_atom, result.hit_atom);
          check_field("hit_wall", e.hit_wall, result.hit_wall);
          check_field("reached_end", e.reached_end, result.reached_end);
        end
      end
      if (item_valid && item_ready) expected_q.push_back(particle_step(item));
    end
  end

endmodule

FILE: tb/electron_lattice_step_tb.sv
`timescale 1ns / 1ps

module electron_lattice_step_tb;
  import els_pkg::*;

  logic clk, rst;
  logic item_valid, item_ready, result_valid, result_ready;
  logic cfg_valid, cfg_ready;
  item_t item;
  result_t result;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int errors, pending;

  // stimulus-side copies of the lattice setup
  longint spacing_c, radius_c, rows_c, cols_c, top_c;
  bit idle_on;
  int sent_count, settings_count;
  bit did_hold;
  int hold_left, rx_wait;

  electron_lattice_step DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lattice_checker u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd12 * 64'd3_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls plus one long hold once traffic is going
  initial begin
    result_ready = 1'b0;
    hold_left = 0;
    rx_wait = 0;
    did_hold = 1'b0;
    forever begin
      @(negedge clk);
      if (!did_hold && sent_count >= 300) begin
        did_hold = 1'b1;
        hold_left = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
      @(posedge clk);
      if (result_valid && result_ready) rx_wait = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  task automatic write_reg(cfg_reg_t idx, longint val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // waits for the block to drain, then rewrites every register
  task automatic apply_setting(longint b, longint dt, longint sp, longint rad,
                               longint rows, longint cols, longint top, longint fin);
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    write_reg(REG_BOOST, b);
    write_reg(REG_DT, dt);
    write_reg(REG_SPACING, sp);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    write_reg(REG_TOP, top);
    write_reg(REG_END, fin);
    spacing_c = sp & 24'hFFFFFF;
    radius_c = rad & 24'hFFFFFF;
    rows_c = rows & 11'h7FF;
    cols_c = cols & 11'h7FF;
    top_c = top;
    settings_count++;
  endtask

  task automatic send_request(item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    sent_count++;
  endtask

  function automatic item_t load_req(longint x, longint y, longint vx, longint vy);
    item_t it;
    it.operation = 1'b1;
    it.load_x = x[31:0];
    it.load_y = y[31:0];
    it.load_vx = vx[31:0];
    it.load_vy = vy[31:0];
    return it;
  endfunction

  function automatic item_t tick_req();
    item_t it;
    it = load_req($urandom, $urandom, $urandom, $urandom);
    it.operation = 1'b0;
    return it;
  endfunction

  function automatic longint small_offset(longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly ticks, some loads next to an atom, a few wild loads
  function automatic item_t random_request();
    longint c, r, span, x, y;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return load_req($urandom, $urandom, $urandom, $urandom);
    if (pick < 30 && rows_c != 0 && cols_c != 0) begin
      c = $urandom_range(0, cols_c > 20 ? 19 : cols_c - 1);
      r = $urandom_range(0, rows_c > 20 ? 19 : rows_c - 1);
      span = radius_c + radius_c / 4 + 2;
      if (span > 64'sd1000000000) span = 64'sd1000000000;
      x = c * spacing_c + small_offset(span);
      y = r * spacing_c + small_offset(span);
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      return load_req(x, y, small_offset(64'sd262144), small_offset(64'sd262144));
    end
    return tick_req();
  endfunction

  task automatic random_batch(int n);
    repeat (n) send_request(random_request());
  endtask

  initial begin
    longint sp;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent_count = 0;
    settings_count = 0;
    idle_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: small lattice, no boost, unit time step
    apply_setting(0, 65536, 262144, 65536, 5, 5, 1310720, 524288);
    send_request(load_req(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647));
    send_request(tick_req());
    send_request(load_req(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                          -64'sd2147483648));
    send_request(tick_req());
    // dead center of an atom
    send_request(load_req(262144, 262144, 0, 0));
    send_request(tick_req());
    // glancing hit, pushed back out to the radius
    send_request(load_req(294912, 262144, -16384, 8192));
    send_request(tick_req());
    // top and bottom walls
    send_request(load_req(131072, 1277952, 0, 65536));
    send_request(tick_req());
    send_request(load_req(131072, 32768, 0, -65536));
    send_request(tick_req());
    // finish line and far outside the lattice
    send_request(load_req(524288, 131072, 0, 0));
    send_request(tick_req());
    send_request(load_req(6553600, 1048576, 65536, 0));
    send_request(tick_req());
    send_request(tick_req());

    // random phases over several register settings
    apply_setting(6553600, 655, 655360, 65536, 11, 101, 6553600, 65536000);
    random_batch(90);
    idle_on = 1'b0;
    apply_setting(24'hFFFFFF, 17'h1FFFF, 24'hFFFFFF, 24'hFFFFFF, 11'h7FF, 11'h7FF,
                  31'h7FFFFFFF, 31'h7FFFFFFF);
    random_batch(90);
    idle_on = 1'b1;
    apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
    random_batch(50);
    apply_setting(65536, 6553, 65536, 131072, 1, 1, 131072, 65536);
    random_batch(60);
    repeat (3) begin
      sp = $urandom_range(65536, 65536 * 32);
      apply_setting($urandom_range(0, 24'hFFFFFF), $urandom_range(1, 65536), sp,
                    $urandom_range(0, sp / 2 - 1), $urandom_range(1, 16),
                    $urandom_range(1, 64), sp * $urandom_range(2, 16),
                    $urandom_range(0, 31'h7FFFFFFF));
      random_batch(85);
      idle_on = ~idle_on;
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    $display("Covered %0d requests (loads and ticks) over %0d register settings,",
             sent_count, settings_count);
    $display("including both register extremes, an empty lattice and a long output stall.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/els_pkg.sv
design/els_mul.sv
design/els_divsqrt.sv
design/electron_lattice_step.sv
tb/lattice_checker.sv
tb/electron_lattice_step_tb.sv
